@@ hdl/tcc_pkg.sv @@
`default_nettype none

package tcc_pkg;

    // Configuration register widths and indexes
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_SEPARATION  = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MATCH_TOLERANCE = 8'd1;

    localparam logic [CFG_DATA_BITS-1:0] MIN_SEPARATION_RESET  = 24'd819;
    localparam logic [CFG_DATA_BITS-1:0] MATCH_TOLERANCE_RESET = 24'd410;

    // Result reason codes
    localparam logic [1:0] FAIL_NONE       = 2'd0;
    localparam logic [1:0] FAIL_SRC_SHORT  = 2'd1;
    localparam logic [1:0] FAIL_DST_SHORT  = 2'd2;
    localparam logic [1:0] FAIL_MISMATCH   = 2'd3;

    // Sum of squares sequence: difference, square, accumulate over three axes
    localparam logic [2:0] SUM_STEP_LAST = 3'd4;
    localparam logic [2:0] SIDE_LAST     = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_LOAD,
        ST_ROOT,
        ST_CHECK,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       capture;     // take the input word into a point slot
        logic [1:0] slot;        // point slot 0..2
        logic       clear_flags; // start of a new triple
        logic       is_target;   // side belongs to the target triangle
        logic [1:0] pair;        // side 0: p0-p1, 1: p0-p2, 2: p1-p2
        logic [1:0] axis;        // coordinate for the difference stage
        logic       diff_en;
        logic       sq_en;
        logic       acc_clear;
        logic       acc_en;
        logic       root_load;
        logic       root_step;
        logic       check;
        logic       emit;
    } cmd_t;

endpackage

`default_nettype wire

@@ hdl/tcc_ctrl.sv @@
`default_nettype none

module tcc_ctrl
    import tcc_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output logic      done,
    output cmd_t      cmd
);

    localparam int ROOT_BITS = COORD_BITS + 1;
    localparam int ITER_BITS = $clog2(ROOT_BITS);
    localparam logic [ITER_BITS-1:0] ITER_LAST = ITER_BITS'(ROOT_BITS - 1);

    state_t               state_reg, state_next;
    logic [1:0]           pair_count_reg, pair_count_next;
    logic [2:0]           side_reg, side_next;
    logic [2:0]           step_reg, step_next;
    logic [ITER_BITS-1:0] iter_reg, iter_next;
    logic                 done_reg, done_next;
    logic                 accept;

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pair_count_reg <= 2'd0;
            side_reg       <= 3'd0;
            step_reg       <= 3'd0;
            iter_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pair_count_reg <= pair_count_next;
            side_reg       <= side_next;
            step_reg       <= step_next;
            iter_reg       <= iter_next;
            done_reg       <= done_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign accept = start && !busy;

    // Sequence the six sides and issue datapath commands
    always_comb
    begin
        state_next      = state_reg;
        pair_count_next = pair_count_reg;
        side_next       = side_reg;
        step_next       = step_reg;
        iter_next       = iter_reg;
        done_next       = 1'b0;

        cmd             = '0;
        cmd.is_target   = (side_reg >= 3'd3);
        cmd.pair        = (side_reg >= 3'd3) ? 2'(side_reg - 3'd3) : side_reg[1:0];
        cmd.axis        = step_reg[1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    cmd.slot    = pair_count_reg;
                    if (pair_count_reg < 2'd2)
                    begin
                        pair_count_next = pair_count_reg + 2'd1;
                    end
                    else
                    begin
                        // third point: run the whole triple
                        pair_count_next = 2'd0;
                        cmd.clear_flags = 1'b1;
                        side_next       = 3'd0;
                        step_next       = 3'd0;
                        state_next      = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.acc_clear = (step_reg == 3'd0);
                cmd.diff_en   = (step_reg < 3'd3);
                cmd.sq_en     = (step_reg >= 3'd1) && (step_reg <= 3'd3);
                cmd.acc_en    = (step_reg >= 3'd2);
                // square and sum stages trail the difference stage
                cmd.axis      = step_reg[1:0];
                if (step_reg == SUM_STEP_LAST)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_LOAD:
            begin
                cmd.root_load = 1'b1;
                iter_next     = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (iter_reg == ITER_LAST)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    iter_next = iter_reg + ITER_BITS'(1);
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                step_next = 3'd0;
                if (side_reg == SIDE_LAST)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    side_next  = side_reg + 3'd1;
                    state_next = ST_SUM;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/tcc_datapath.sv @@
`default_nettype none

module tcc_datapath
    import tcc_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cmd_t                        cmd,
    input  wire logic signed [COORD_BITS-1:0] src_x,
    input  wire logic signed [COORD_BITS-1:0] src_y,
    input  wire logic signed [COORD_BITS-1:0] src_z,
    input  wire logic signed [COORD_BITS-1:0] dst_x,
    input  wire logic signed [COORD_BITS-1:0] dst_y,
    input  wire logic signed [COORD_BITS-1:0] dst_z,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]    cfg_data,
    output logic                             accepted,
    output logic [1:0]                       fail_reason
);

    localparam int CB        = COORD_BITS;
    localparam int SUM_BITS  = 2 * CB + 2;
    localparam int ROOT_BITS = CB + 1;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int CMP_BITS  = (ROOT_BITS > CFG_DATA_BITS) ? ROOT_BITS : CFG_DATA_BITS;

    // Held points, three slots for source and target
    logic [CB-1:0] sx_reg [3];
    logic [CB-1:0] sy_reg [3];
    logic [CB-1:0] sz_reg [3];
    logic [CB-1:0] tx_reg [3];
    logic [CB-1:0] ty_reg [3];
    logic [CB-1:0] tz_reg [3];

    logic [CFG_DATA_BITS-1:0] min_sep_reg;
    logic [CFG_DATA_BITS-1:0] match_tol_reg;

    logic [CB-1:0]        diff_reg;
    logic [2*CB-1:0]      sq_reg;
    logic [SUM_BITS-1:0]  acc_reg;
    logic [SUM_BITS-1:0]  rad_reg;
    logic [REM_BITS-1:0]  rem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [ROOT_BITS-1:0] ls_reg [3];

    logic src_short_reg, dst_short_reg, mismatch_reg;
    logic accepted_reg;
    logic [1:0] fail_reason_reg;

    logic [1:0]           idx_a, idx_b;
    logic [CB-1:0]        op_a, op_b;
    logic [CB:0]          dsub, dneg;
    logic [CB-1:0]        dmag;
    logic [REM_BITS+1:0]  shifted, trial, rem_sub;
    logic                 root_ge;
    logic [ROOT_BITS-1:0] src_len, len_diff;
    logic                 len_short, len_mismatch;
    logic [1:0]           reason;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sep_reg   <= MIN_SEPARATION_RESET;
            match_tol_reg <= MATCH_TOLERANCE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MIN_SEPARATION)
            begin
                min_sep_reg <= cfg_data;
            end
            else if (cfg_index == CFG_MATCH_TOLERANCE)
            begin
                match_tol_reg <= cfg_data;
            end
        end
    end

    // Capture the input word into its slot
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sx_reg[cmd.slot] <= src_x;
            sy_reg[cmd.slot] <= src_y;
            sz_reg[cmd.slot] <= src_z;
            tx_reg[cmd.slot] <= dst_x;
            ty_reg[cmd.slot] <= dst_y;
            tz_reg[cmd.slot] <= dst_z;
        end
    end

    // Select the two end points of the current side
    always_comb
    begin
        unique case (cmd.pair)
            2'd0:    begin idx_a = 2'd0; idx_b = 2'd1; end
            2'd1:    begin idx_a = 2'd0; idx_b = 2'd2; end
            default: begin idx_a = 2'd1; idx_b = 2'd2; end
        endcase

        unique case ({cmd.is_target, cmd.axis})
            3'b000:  begin op_a = sx_reg[idx_a]; op_b = sx_reg[idx_b]; end
            3'b001:  begin op_a = sy_reg[idx_a]; op_b = sy_reg[idx_b]; end
            3'b010:  begin op_a = sz_reg[idx_a]; op_b = sz_reg[idx_b]; end
            3'b100:  begin op_a = tx_reg[idx_a]; op_b = tx_reg[idx_b]; end
            3'b101:  begin op_a = ty_reg[idx_a]; op_b = ty_reg[idx_b]; end
            3'b110:  begin op_a = tz_reg[idx_a]; op_b = tz_reg[idx_b]; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    // Magnitude of the coordinate difference always fits in CB bits
    assign dsub = {op_a[CB-1], op_a} - {op_b[CB-1], op_b};
    assign dneg = ~dsub + (CB+1)'(1);
    assign dmag = dsub[CB] ? dneg[CB-1:0] : dsub[CB-1:0];

    // Difference, square and sum of squares, one axis a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.diff_en)
        begin
            diff_reg <= dmag;
        end
        if (cmd.sq_en)
        begin
            sq_reg <= diff_reg * diff_reg;
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + {2'b00, sq_reg};
        end
    end

    // One root bit per cycle, two radicand bits shifted in each step
    assign shifted = {rem_reg, rad_reg[SUM_BITS-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign root_ge = (shifted >= trial);
    assign rem_sub = shifted - trial;

    always_ff @(posedge clk)
    begin
        if (cmd.root_load)
        begin
            rad_reg  <= acc_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[SUM_BITS-3:0], 2'b00};
            rem_reg  <= root_ge ? rem_sub[REM_BITS-1:0] : shifted[REM_BITS-1:0];
            root_reg <= {root_reg[ROOT_BITS-2:0], root_ge};
        end
    end

    // Compare the finished side with the limits and its source partner
    assign src_len      = ls_reg[cmd.pair];
    assign len_diff     = (root_reg >= src_len) ? (root_reg - src_len) : (src_len - root_reg);
    assign len_short    = (CMP_BITS'(root_reg) < CMP_BITS'(min_sep_reg));
    assign len_mismatch = (CMP_BITS'(len_diff) > CMP_BITS'(match_tol_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.check && !cmd.is_target)
        begin
            ls_reg[cmd.pair] <= root_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_short_reg <= 1'b0;
            dst_short_reg <= 1'b0;
            mismatch_reg  <= 1'b0;
        end
        else if (cmd.clear_flags)
        begin
            src_short_reg <= 1'b0;
            dst_short_reg <= 1'b0;
            mismatch_reg  <= 1'b0;
        end
        else if (cmd.check)
        begin
            if (!cmd.is_target && len_short)
            begin
                src_short_reg <= 1'b1;
            end
            if (cmd.is_target && len_short)
            begin
                dst_short_reg <= 1'b1;
            end
            if (cmd.is_target && len_mismatch)
            begin
                mismatch_reg <= 1'b1;
            end
        end
    end

    // Source short wins over target short, which wins over mismatch
    always_comb
    begin
        priority if (src_short_reg)
        begin
            reason = FAIL_SRC_SHORT;
        end
        else if (dst_short_reg)
        begin
            reason = FAIL_DST_SHORT;
        end
        else if (mismatch_reg)
        begin
            reason = FAIL_MISMATCH;
        end
        else
        begin
            reason = FAIL_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            fail_reason_reg <= reason;
            accepted_reg    <= (reason == FAIL_NONE);
        end
    end

    assign accepted    = accepted_reg;
    assign fail_reason = fail_reason_reg;

endmodule

`default_nettype wire

@@ hdl/triangle_correspondence_check.sv @@
// The first two words of a triple are taken while idle; after the third word the result
// is strobed on done. No word is taken while busy, so a new triple waits for the result.
// The six sides run in turn through the shared root unit, which produces one bit per
// cycle for each side.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset clears the controller and flags and loads the configuration defaults; held points stay undefined.
`default_nettype none

module triangle_correspondence_check
    import tcc_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] src_x,
    input  wire logic signed [COORD_BITS-1:0] src_y,
    input  wire logic signed [COORD_BITS-1:0] src_z,
    input  wire logic signed [COORD_BITS-1:0] dst_x,
    input  wire logic signed [COORD_BITS-1:0] dst_y,
    input  wire logic signed [COORD_BITS-1:0] dst_z,
    output logic                              done,
    output logic                              accepted,
    output logic [1:0]                        fail_reason,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]     cfg_data
);

    cmd_t cmd;
    logic cfg_we;

    // Configuration writes are taken in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    tcc_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    tcc_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .src_x       (src_x),
        .src_y       (src_y),
        .src_z       (src_z),
        .dst_x       (dst_x),
        .dst_y       (dst_y),
        .dst_z       (dst_z),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accepted    (accepted),
        .fail_reason (fail_reason)
    );

endmodule

`default_nettype wire
